// ===== src/efdc_pkg.sv =====
package efdc_pkg;

  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] CFG_DELIMITER   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_ESCAPE      = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_ESC_DELIM   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_ESC_ESCAPE  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_CHECKSUM    = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_MIN_RAW_LEN = 3'd5;

  localparam logic [7:0] RST_DELIMITER   = 8'd126;
  localparam logic [7:0] RST_ESCAPE      = 8'd127;
  localparam logic [7:0] RST_ESC_DELIM   = 8'd128;
  localparam logic [7:0] RST_ESC_ESCAPE  = 8'd129;
  localparam logic [7:0] RST_CHECKSUM    = 8'h55;
  localparam logic [7:0] RST_MIN_RAW_LEN = 8'd45;

  // raw bytes without a delimiter before the frame is thrown away
  localparam logic [8:0] RAW_LIMIT = 9'd255;

  // decoded count saturates here
  localparam logic [6:0] DCOUNT_MAX = 7'd127;

  typedef logic [1:0] status_t;

  localparam status_t STATUS_OK      = 2'd0;
  localparam status_t STATUS_BAD_ESC = 2'd1;
  localparam status_t STATUS_SUM     = 2'd2;
  localparam status_t STATUS_LENGTH  = 2'd3;

  typedef struct packed {
    logic [7:0] delimiter;
    logic [7:0] escape;
    logic [7:0] esc_delim;
    logic [7:0] esc_escape;
    logic [7:0] checksum;
    logic [7:0] min_raw_len;
  } cfg_t;

  // one closed frame handed from front to back
  typedef struct packed {
    logic    emit;
    status_t status;
    logic    bank;
  } cmd_t;

endpackage

// ===== src/efdc_ram.sv =====
module efdc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

// ===== src/efdc_front.sv =====
module efdc_front import efdc_pkg::*; #(
  parameter int unsigned FRAME_LEN   = 44,
  parameter int unsigned STORE_DEPTH = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  cfg_t                             cfg_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [7:0]                       rx_byte_i,
  input  logic                             fifo_full_i,
  input  logic                             frame_done_i,
  output logic                             push_o,
  output cmd_t                             cmd_o,
  output logic                             wr_en_o,
  output logic [$clog2(STORE_DEPTH):0]     wr_addr_o,
  output logic [7:0]                       wr_data_o
);

  localparam int unsigned AW = $clog2(STORE_DEPTH);
  localparam logic [6:0] FULL_CNT = 7'(FRAME_LEN + 1);
  localparam logic [8:0] DEPTH9 = 9'(STORE_DEPTH);

  logic [7:0] raw_q, raw_d;
  logic       pend_q, pend_d;
  logic       err_q, err_d;
  logic [7:0] sum_q, sum_d;
  logic [6:0] cnt_q, cnt_d;
  logic       bank_q, bank_d;
  logic [1:0] outst_q, outst_d;

  logic       accept;
  logic       is_delim;
  logic       app_en;
  logic [7:0] app_byte;
  logic [8:0] raw_inc;
  logic [7:0] cnt_ext;
  logic       tail_esc;
  logic [7:0] fin_sum;
  logic [6:0] fin_cnt;
  logic       examine;
  status_t    fin_status;

  // a bank is busy until the back has sent all of its bytes
  assign in_ready_o = !fifo_full_i && (outst_q != 2'd2);
  assign accept     = in_valid_i && in_ready_o;
  assign is_delim   = (rx_byte_i == cfg_i.delimiter);
  assign raw_inc    = {1'b0, raw_q} + 9'd1;
  assign cnt_ext    = {1'b0, cnt_q};

  always_comb begin
    app_en   = 1'b0;
    app_byte = rx_byte_i;
    pend_d   = pend_q;
    err_d    = err_q;
    if (!err_q) begin
      if (pend_q) begin
        pend_d = 1'b0;
        if (rx_byte_i == cfg_i.esc_delim) begin
          app_en   = 1'b1;
          app_byte = cfg_i.delimiter;
        end else if (rx_byte_i == cfg_i.esc_escape) begin
          app_en   = 1'b1;
          app_byte = cfg_i.escape;
        end else begin
          err_d = 1'b1;
        end
      end else if (rx_byte_i == cfg_i.escape) begin
        pend_d = 1'b1;
      end else begin
        app_en = 1'b1;
      end
    end
  end

  // frame close: a trailing escape counts as a literal
  always_comb begin
    tail_esc = pend_q && !err_q;
    fin_sum  = sum_q + (tail_esc ? cfg_i.escape : 8'd0);
    fin_cnt  = (tail_esc && (cnt_q != DCOUNT_MAX)) ? cnt_q + 7'd1 : cnt_q;
    examine  = (raw_q >= cfg_i.min_raw_len);
    if (err_q) begin
      fin_status = STATUS_BAD_ESC;
    end else if (fin_sum != cfg_i.checksum) begin
      fin_status = STATUS_SUM;
    end else if (fin_cnt != FULL_CNT) begin
      fin_status = STATUS_LENGTH;
    end else begin
      fin_status = STATUS_OK;
    end
  end

  assign push_o       = accept && is_delim && examine;
  assign cmd_o.emit   = (fin_status == STATUS_OK);
  assign cmd_o.status = fin_status;
  assign cmd_o.bank   = bank_q;

  assign wr_en_o   = accept && !is_delim && app_en && ({1'b0, cnt_ext} < DEPTH9);
  assign wr_addr_o = {bank_q, cnt_ext[AW-1:0]};
  assign wr_data_o = app_byte;

  always_comb begin
    raw_d  = raw_q;
    sum_d  = sum_q;
    cnt_d  = cnt_q;
    bank_d = bank_q;
    if (accept) begin
      if (is_delim) begin
        raw_d = 8'd0;
        sum_d = 8'd0;
        cnt_d = 7'd0;
        if (push_o && cmd_o.emit) begin
          bank_d = !bank_q;
        end
      end else begin
        raw_d = raw_inc[7:0];
        if (app_en) begin
          sum_d = sum_q + app_byte;
          if (cnt_q != DCOUNT_MAX) begin
            cnt_d = cnt_q + 7'd1;
          end
        end
        if (raw_inc >= RAW_LIMIT) begin
          raw_d = 8'd0;
          sum_d = 8'd0;
          cnt_d = 7'd0;
        end
      end
    end
  end

  always_comb begin
    outst_d = outst_q;
    if ((push_o && cmd_o.emit) && !frame_done_i) begin
      outst_d = outst_q + 2'd1;
    end else if (!(push_o && cmd_o.emit) && frame_done_i) begin
      outst_d = outst_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_q   <= 8'd0;
      pend_q  <= 1'b0;
      err_q   <= 1'b0;
      sum_q   <= 8'd0;
      cnt_q   <= 7'd0;
      bank_q  <= 1'b0;
      outst_q <= 2'd0;
    end else begin
      raw_q   <= raw_d;
      sum_q   <= sum_d;
      cnt_q   <= cnt_d;
      bank_q  <= bank_d;
      outst_q <= outst_d;
      if (accept) begin
        if (is_delim || (raw_inc >= RAW_LIMIT)) begin
          pend_q <= 1'b0;
          err_q  <= 1'b0;
        end else begin
          pend_q <= pend_d;
          err_q  <= err_d;
        end
      end
    end
  end

  a_outst_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    outst_q != 2'd3)
    else $error("more payload frames in flight than banks");

  a_done_has_frame : assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_done_i |-> outst_q != 2'd0)
    else $error("frame finished with none in flight");

  a_no_write_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_o |-> outst_q != 2'd2)
    else $error("write into a bank still being read");

endmodule

// ===== src/efdc_cmd_fifo.sv =====
module efdc_cmd_fifo import efdc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  input  logic pop_i,
  output cmd_t cmd_o,
  output logic empty_o,
  output logic full_o
);

  cmd_t       entry_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q;

  assign empty_o = (count_q == 2'd0);
  assign full_o  = (count_q == 2'd2);
  assign cmd_o   = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("command queue overflow");

  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("command queue underflow");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("command queue count out of range");

endmodule

// ===== src/efdc_back.sv =====
module efdc_back import efdc_pkg::*; #(
  parameter int unsigned FRAME_LEN   = 44,
  parameter int unsigned STORE_DEPTH = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         fifo_empty_i,
  input  cmd_t                         cmd_i,
  output logic                         pop_o,
  output logic                         rd_en_o,
  output logic [$clog2(STORE_DEPTH):0] rd_addr_o,
  input  logic [7:0]                   rd_data_i,
  output logic                         frame_done_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [7:0]                   payload_byte_o,
  output logic [1:0]                   frame_status_o,
  output logic                         last_of_frame_o
);

  localparam int unsigned AW = $clog2(STORE_DEPTH);
  localparam int unsigned KW = $clog2(FRAME_LEN + 1);
  localparam logic [KW-1:0] K_LAST = KW'(FRAME_LEN - 1);
  localparam logic [8:0] DEPTH9 = 9'(STORE_DEPTH);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_READ   = 2'd1;
  localparam logic [1:0] ST_LOAD   = 2'd2;
  localparam logic [1:0] ST_STATUS = 2'd3;

  logic [1:0]    state_q, state_d;
  cmd_t          cmd_q;
  logic [KW-1:0] k_q, k_d;
  logic          beyond_q;
  logic          last_q;
  logic          out_valid_q;
  logic [7:0]    out_byte_q;
  status_t       out_status_q;
  logic          out_last_q;

  logic       slot_free;
  logic       load_word;
  logic       load_status;
  logic [7:0] k_ext;
  logic       beyond;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign pop_o       = (state_q == ST_IDLE) && !fifo_empty_i;
  assign load_word   = (state_q == ST_LOAD) && slot_free;
  assign load_status = (state_q == ST_STATUS) && slot_free;

  assign k_ext     = 8'(k_q);
  assign beyond    = ({1'b0, k_ext} >= DEPTH9);
  assign rd_en_o   = (state_q == ST_READ);
  assign rd_addr_o = {cmd_q.bank, k_ext[AW-1:0]};

  assign frame_done_o = load_word && last_q;

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    unique case (state_q)
      ST_IDLE: begin
        if (!fifo_empty_i) begin
          k_d     = '0;
          state_d = cmd_i.emit ? ST_READ : ST_STATUS;
        end
      end
      ST_READ: begin
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        if (slot_free) begin
          if (last_q) begin
            state_d = ST_IDLE;
          end else begin
            k_d     = k_q + KW'(1);
            state_d = ST_READ;
          end
        end
      end
      ST_STATUS: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      if (load_word || load_status) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q <= cmd_i;
    end
    if (rd_en_o) begin
      beyond_q <= beyond;
      last_q   <= (k_q == K_LAST);
    end
    if (load_word) begin
      // bytes past the end of the store read as zero
      out_byte_q   <= beyond_q ? 8'd0 : rd_data_i;
      out_status_q <= STATUS_OK;
      out_last_q   <= last_q;
    end else if (load_status) begin
      out_byte_q   <= 8'd0;
      out_status_q <= cmd_q.status;
      out_last_q   <= 1'b1;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign payload_byte_o  = out_byte_q;
  assign frame_status_o  = out_status_q;
  assign last_of_frame_o = out_last_q;

  a_done_marks_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_done_o |=> out_valid_o && last_of_frame_o && (frame_status_o == STATUS_OK))
    else $error("payload frame ended without a marked last word");

  a_status_word : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (frame_status_o != STATUS_OK) |-> last_of_frame_o && (payload_byte_o == 8'd0))
    else $error("error word with data or without last mark");

  a_read_then_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en_o |=> state_q == ST_LOAD)
    else $error("store read not followed by load");

endmodule

// ===== src/escaped_frame_deframer_checksum_core.sv =====
// channel  | direction | handshake               | payload
// rx       | in        | in_valid_i / in_ready_o | rx_byte_i
// result   | out       | out_valid_o/out_ready_i | payload_byte_o, frame_status_o, last_of_frame_o
// config   | in        | cfg_we_i                | cfg_index_i, cfg_data_i
//
// the front takes one received byte per cycle while in_ready_o is high and decodes escapes as it goes
// a good frame sends FRAME_LEN words after its delimiter, each loaded before the next store read starts
// an errored frame sends one status word once its delimiter is accepted
// result stalls hold the back in place: each word waits for its store read, then load
// rx stalls while both store banks hold frames still being sent, or the queue is full
// no clearing pass after reset: store entries are only read once written
module escaped_frame_deframer_checksum_core import efdc_pkg::*; #(
  parameter int unsigned FRAME_LEN   = 44,
  parameter int unsigned STORE_DEPTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]         cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         rx_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         payload_byte_o,
  output logic [1:0]         frame_status_o,
  output logic               last_of_frame_o
);

  localparam int unsigned AW = $clog2(STORE_DEPTH);
  localparam int unsigned RAM_DEPTH = 2 << AW;

  cfg_t cfg_q;

  logic          push;
  cmd_t          push_cmd;
  cmd_t          head_cmd;
  logic          pop;
  logic          fifo_empty;
  logic          fifo_full;
  logic          frame_done;
  logic          wr_en;
  logic [AW:0]   wr_addr;
  logic [7:0]    wr_data;
  logic          rd_en;
  logic [AW:0]   rd_addr;
  logic [7:0]    rd_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.delimiter   <= RST_DELIMITER;
      cfg_q.escape      <= RST_ESCAPE;
      cfg_q.esc_delim   <= RST_ESC_DELIM;
      cfg_q.esc_escape  <= RST_ESC_ESCAPE;
      cfg_q.checksum    <= RST_CHECKSUM;
      cfg_q.min_raw_len <= RST_MIN_RAW_LEN;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_DELIMITER:   cfg_q.delimiter   <= cfg_data_i;
        CFG_ESCAPE:      cfg_q.escape      <= cfg_data_i;
        CFG_ESC_DELIM:   cfg_q.esc_delim   <= cfg_data_i;
        CFG_ESC_ESCAPE:  cfg_q.esc_escape  <= cfg_data_i;
        CFG_CHECKSUM:    cfg_q.checksum    <= cfg_data_i;
        CFG_MIN_RAW_LEN: cfg_q.min_raw_len <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  efdc_front #(
    .FRAME_LEN  (FRAME_LEN),
    .STORE_DEPTH(STORE_DEPTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .rx_byte_i   (rx_byte_i),
    .fifo_full_i (fifo_full),
    .frame_done_i(frame_done),
    .push_o      (push),
    .cmd_o       (push_cmd),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data)
  );

  efdc_ram #(
    .WIDTH(8),
    .DEPTH(RAM_DEPTH)
  ) u_store (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  efdc_cmd_fifo u_cmd_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .pop_i  (pop),
    .cmd_o  (head_cmd),
    .empty_o(fifo_empty),
    .full_o (fifo_full)
  );

  efdc_back #(
    .FRAME_LEN  (FRAME_LEN),
    .STORE_DEPTH(STORE_DEPTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fifo_empty_i   (fifo_empty),
    .cmd_i          (head_cmd),
    .pop_o          (pop),
    .rd_en_o        (rd_en),
    .rd_addr_o      (rd_addr),
    .rd_data_i      (rd_data),
    .frame_done_o   (frame_done),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .payload_byte_o (payload_byte_o),
    .frame_status_o (frame_status_o),
    .last_of_frame_o(last_of_frame_o)
  );

endmodule
